[src/vn_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vn_pkg
// Shared widths and pipeline depths of the vector normalize core.
// ---------------------------------------------------------------------------
package vn_pkg;

  localparam int unsigned CompW   = 32;              // component width
  localparam int unsigned SqW     = 64;              // square and sum width
  localparam int unsigned LenW    = 32;              // length width
  localparam int unsigned NumW    = 62;              // dividend width, |c| << 30
  localparam int unsigned QuoW    = 31;              // quotient width
  localparam int unsigned SqrtLat = SqW / 2;         // one root bit per stage
  localparam int unsigned DivLat  = QuoW;            // one quotient bit per stage
  localparam int unsigned FrontLat = 3;              // magnitude, square, sum
  localparam int unsigned PipeLat = FrontLat + SqrtLat + DivLat;

  localparam logic [CompW-1:0] UnitOne = 32'h4000_0000;

endpackage

[src/vn_isqrt.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vn_isqrt
// Pipelined 64-bit integer square root, rounded down, one root bit per stage.
// ---------------------------------------------------------------------------
module vn_isqrt
  import vn_pkg::*;
(
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [SqW-1:0]  rad_i,
  output logic [LenW-1:0] root_o
);

  logic [SqW-1:0] v_q [SqrtLat];
  logic [SqW-1:0] r_q [SqrtLat];

  // one digit-by-digit step per stage
  for (genvar k = 0; k < SqrtLat; k++) begin : g_stage
    localparam logic [SqW-1:0] Bit = SqW'(1) << (SqW - 2 - 2 * k);
    logic [SqW-1:0] v_in, r_in, trial, v_d, r_d;

    if (k == 0) begin : g_first
      assign v_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
    end

    always_comb begin
      trial = r_in + Bit;
      if (v_in >= trial) begin
        v_d = v_in - trial;
        r_d = (r_in >> 1) + Bit;
      end else begin
        v_d = v_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k] <= v_d;
        r_q[k] <= r_d;
      end
    end
  end

  assign root_o = r_q[SqrtLat-1][LenW-1:0];

endmodule

[src/vn_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vn_div
// Pipelined restoring divider, 62-bit dividend by 32-bit divisor, quotient
// known to stay below 2^31, one quotient bit per stage.
// ---------------------------------------------------------------------------
module vn_div
  import vn_pkg::*;
(
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [LenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o
);

  logic [LenW-1:0] rem_q [DivLat];
  logic [QuoW-1:0] lo_q  [DivLat];   // unused dividend bits, msb first
  logic [QuoW-1:0] quo_q [DivLat];
  logic [LenW-1:0] den_q [DivLat];

  for (genvar k = 0; k < DivLat; k++) begin : g_stage
    logic [LenW-1:0] rem_in, den_in, rem_d;
    logic [QuoW-1:0] lo_in, quo_in;
    logic [LenW:0]   trial;
    logic            qbit;

    // high dividend bits already sit below the divisor
    if (k == 0) begin : g_first
      assign rem_in = {1'b0, num_i[NumW-1:QuoW]};
      assign lo_in  = num_i[QuoW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_comb begin
      trial = {rem_in, lo_in[QuoW-1]};
      qbit  = (trial >= {1'b0, den_in});
      if (qbit) begin
        rem_d = LenW'(trial - {1'b0, den_in});
      end else begin
        rem_d = trial[LenW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        lo_q[k]  <= {lo_in[QuoW-2:0], 1'b0};
        quo_q[k] <= {quo_in[QuoW-2:0], qbit};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DivLat-1];

endmodule

[src/vector3_normalize_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector3_normalize_core
// Normalizes a Q16.16 3d vector to a Q2.30 unit vector, zero flag on zero.
// ---------------------------------------------------------------------------
// pipeline: input word to output word through 3 front stages,
//   32 square root stages, 31 divider stages and 1 output register
// throughput: one word per cycle; the whole pipeline holds while a result
//   waits at the output register
// reset: rst_ni clears the valid bits only, data registers are not reset
module vector3_normalize_core
  import vn_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [95:0]    s_axis_tdata_i,   // in_x, in_y, in_z
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [95:0]    m_axis_tdata_o,   // out_x, out_y, out_z
  output logic           m_axis_tuser_o    // is_zero
);

  logic en;
  logic [PipeLat-1:0] vld_q;
  logic out_vld_q;

  // advance whenever the output slot is free or being taken
  assign en = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[PipeLat-2:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[PipeLat-1];
    end
  end

  // stage 1: magnitudes and signs
  logic [CompW-1:0] mag1_q [3];
  logic [2:0]       neg1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1_q[i] <= s_axis_tdata_i[CompW*i+CompW-1];
        mag1_q[i] <= s_axis_tdata_i[CompW*i+CompW-1]
                     ? CompW'(-s_axis_tdata_i[CompW*i +: CompW])
                     : s_axis_tdata_i[CompW*i +: CompW];
      end
    end
  end

  // stage 2: squares
  logic [SqW-1:0]   sq2_q  [3];
  logic [CompW-1:0] mag2_q [3];
  logic [2:0]       neg2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2_q[i]  <= SqW'(mag1_q[i]) * SqW'(mag1_q[i]);
        mag2_q[i] <= mag1_q[i];
      end
      neg2_q <= neg1_q;
    end
  end

  // stage 3: sum of squares, at most 3 * 2^62
  logic [SqW-1:0]   sum3_q;
  logic [CompW-1:0] mag3_q [3];
  logic [2:0]       neg3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum3_q <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      mag3_q <= mag2_q;
      neg3_q <= neg2_q;
    end
  end

  // square root with side delay line for magnitudes and signs
  logic [LenW-1:0]  len;
  logic [CompW-1:0] magd_q [SqrtLat][3];
  logic [2:0]       negd_q [SqrtLat];

  vn_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum3_q),
    .root_o (len)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      magd_q[0] <= mag3_q;
      negd_q[0] <= neg3_q;
      for (int k = 1; k < SqrtLat; k++) begin
        magd_q[k] <= magd_q[k-1];
        negd_q[k] <= negd_q[k-1];
      end
    end
  end

  // three dividers, sign and zero flag ride alongside
  logic [QuoW-1:0] quo [3];
  logic [2:0]      negq_q  [DivLat];
  logic            zeroq_q [DivLat];

  for (genvar i = 0; i < 3; i++) begin : g_div
    vn_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({magd_q[SqrtLat-1][i], 30'd0}),
      .den_i (len),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      negq_q[0]  <= negd_q[SqrtLat-1];
      zeroq_q[0] <= (len == '0);
      for (int k = 1; k < DivLat; k++) begin
        negq_q[k]  <= negq_q[k-1];
        zeroq_q[k] <= zeroq_q[k-1];
      end
    end
  end

  // output register: apply signs, force zero vector on zero length
  logic [95:0] out_data_q;
  logic        out_zero_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_zero_q <= zeroq_q[DivLat-1];
      for (int i = 0; i < 3; i++) begin
        if (zeroq_q[DivLat-1]) begin
          out_data_q[CompW*i +: CompW] <= '0;
        end else if (negq_q[DivLat-1][i]) begin
          out_data_q[CompW*i +: CompW] <= CompW'(-{1'b0, quo[i]});
        end else begin
          out_data_q[CompW*i +: CompW] <= {1'b0, quo[i]};
        end
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_zero_q;

`ifndef SYNTH
  // zero flag always comes with the zero vector
  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("zero flag with nonzero vector");

  // x component never exceeds one in magnitude
  a_unit_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[31:0]) <= $signed(UnitOne) &&
                         $signed(m_axis_tdata_o[31:0]) >= -$signed(UnitOne)))
    else $error("x component out of unit range");

  // input is taken exactly when the pipeline advances
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("ready does not follow pipeline advance");

  // a stalled pipeline drops nothing into the output
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("output word lost during stall");
`endif

endmodule
